// File: sv/chlrs_pkg.sv
// chlrs_pkg: shared types, register indexes, reset values and the 32-bit
// saturation helper for the conic height limit root select block.
// No dependencies.
package chlrs_pkg;

	localparam int COORD_W = 32;
	localparam int UNIT_W  = 18;
	localparam int IDX_W   = 4;
	localparam int PROD_W  = COORD_W + UNIT_W;
	localparam int DOT_W   = PROD_W + 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [UNIT_W-1:0]  unit_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic        [IDX_W-1:0]   cfg_idx_t;

	// configuration register indexes
	localparam cfg_idx_t REG_BASE_X      = 4'd0;
	localparam cfg_idx_t REG_BASE_Y      = 4'd1;
	localparam cfg_idx_t REG_BASE_Z      = 4'd2;
	localparam cfg_idx_t REG_AXIS_X      = 4'd3;
	localparam cfg_idx_t REG_AXIS_Y      = 4'd4;
	localparam cfg_idx_t REG_AXIS_Z      = 4'd5;
	localparam cfg_idx_t REG_HEIGHT_LOW  = 4'd6;
	localparam cfg_idx_t REG_HEIGHT_HIGH = 4'd7;

	// reset values: unit axis along y, height window [0, 1.0]
	localparam unit_t  AXIS_Y_RST      = 18'sd65536;
	localparam coord_t HEIGHT_HIGH_RST = 32'sd65536;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	function automatic coord_t sat32(input logic signed [63:0] v);
		coord_t r;
		if (v > S32_MAX) begin
			r = coord_t'(S32_MAX);
		end else if (v < S32_MIN) begin
			r = coord_t'(S32_MIN);
		end else begin
			r = coord_t'(v);
		end
		return r;
	endfunction

endpackage

// File: sv/conic_height_limit_root_select.sv
// conic_height_limit_root_select: ray vs. finite cylinder/cone height clip.
// Depends on chlrs_pkg (types, register indexes, saturation helper).
//
// Usage:
//   Input channel: a transaction is taken at a rising edge with start high
//   and busy low. busy is always low, so one ray/root pair can be issued in
//   every cycle.
//   Result channel: done is high for exactly one cycle with hit and
//   drop_near valid; the receiver cannot stall, results are never held.
//   hit and drop_near read zero while done is low.
//   Config channel: cfg_valid/cfg_ready write cfg_data into register
//   cfg_index (0..2 base xyz, 3..5 axis xyz, 6 height_low, 7 height_high);
//   other indexes are dropped. cfg_ready is always high. Registers must only
//   change while no transaction is in flight.
//   Pipeline: a transaction passes stages s1 to s7 (seven stages) before
//   done. Throughput: one transaction per cycle, set by the
//   seven-register pipeline with both roots handled in parallel lanes.
//   Reset: arst_n clears all stage valid bits and loads the register reset
//   values (axis = (0,1.0,0), heights [0,1.0], base 0); any transaction in
//   flight is dropped.
module conic_height_limit_root_select #(
	parameter int FRAC_BITS   = 16,
	parameter int MIN_RAY_LEN = 66
) (
	input  logic              clk,
	input  logic              arst_n,
	// ray transaction
	input  logic              start,
	output logic              busy,
	input  chlrs_pkg::unit_t  dir_x,
	input  chlrs_pkg::unit_t  dir_y,
	input  chlrs_pkg::unit_t  dir_z,
	input  chlrs_pkg::coord_t origin_x,
	input  chlrs_pkg::coord_t origin_y,
	input  chlrs_pkg::coord_t origin_z,
	input  chlrs_pkg::coord_t root_a,
	input  chlrs_pkg::coord_t root_b,
	// result
	output logic              done,
	output logic              hit,
	output logic              drop_near,
	// configuration
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  chlrs_pkg::cfg_idx_t cfg_index,
	input  chlrs_pkg::coord_t cfg_data
);
	import chlrs_pkg::*;

	localparam coord_t MIN_LEN = coord_t'(MIN_RAY_LEN);

	// configuration registers
	coord_t base_q [3];
	unit_t  axis_q [3];
	coord_t height_low_q;
	coord_t height_high_q;

	// pipeline: lane 0 = near root, lane 1 = far root
	logic   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic   short_s1, short_s2, short_s3, short_s4, short_s5, short_s6;
	unit_t  dir_s1 [3];
	coord_t org_s1 [3];
	coord_t org_s2 [3];
	coord_t root_s1 [2];
	prod_t  prod_s2 [2][3];
	coord_t p_s3 [2][3];
	coord_t q_s4 [2][3];
	prod_t  dp_s5 [2][3];
	logic   ok_s6 [2];

	logic   in_take;
	logic   a_lt_b;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign in_take   = start & ~busy;
	assign a_lt_b    = root_a < root_b;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q[0]     <= '0;
			base_q[1]     <= '0;
			base_q[2]     <= '0;
			axis_q[0]     <= '0;
			axis_q[1]     <= AXIS_Y_RST;
			axis_q[2]     <= '0;
			height_low_q  <= '0;
			height_high_q <= HEIGHT_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE_X:      base_q[0]     <= cfg_data;
				REG_BASE_Y:      base_q[1]     <= cfg_data;
				REG_BASE_Z:      base_q[2]     <= cfg_data;
				REG_AXIS_X:      axis_q[0]     <= unit_t'(cfg_data[UNIT_W-1:0]);
				REG_AXIS_Y:      axis_q[1]     <= unit_t'(cfg_data[UNIT_W-1:0]);
				REG_AXIS_Z:      axis_q[2]     <= unit_t'(cfg_data[UNIT_W-1:0]);
				REG_HEIGHT_LOW:  height_low_q  <= cfg_data;
				REG_HEIGHT_HIGH: height_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// ---------------- stage valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= in_take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			done   <= vld_s6;
		end
	end

	// ---------------- datapath ----------------
	// s1: order roots, flag a near root shorter than the minimum ray length
	always_ff @(posedge clk) begin
		dir_s1[0]  <= dir_x;
		dir_s1[1]  <= dir_y;
		dir_s1[2]  <= dir_z;
		org_s1[0]  <= origin_x;
		org_s1[1]  <= origin_y;
		org_s1[2]  <= origin_z;
		root_s1[0] <= a_lt_b ? root_a : root_b;
		root_s1[1] <= a_lt_b ? root_b : root_a;
		short_s1   <= (a_lt_b ? root_a : root_b) < MIN_LEN;
	end

	// s2: dir * t, exact
	always_ff @(posedge clk) begin
		for (int r = 0; r < 2; r++) begin
			for (int i = 0; i < 3; i++) begin
				prod_s2[r][i] <= prod_t'(dir_s1[i]) * prod_t'(root_s1[r]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			org_s2[i] <= org_s1[i];
		end
		short_s2 <= short_s1;
	end

	// s3: floor shift, saturate, add origin, saturate
	always_ff @(posedge clk) begin
		for (int r = 0; r < 2; r++) begin
			for (int i = 0; i < 3; i++) begin
				p_s3[r][i] <= sat32(64'(sat32(64'(prod_s2[r][i] >>> FRAC_BITS)))
					+ 64'(org_s2[i]));
			end
		end
		short_s3 <= short_s2;
	end

	// s4: offset from base, saturated
	always_ff @(posedge clk) begin
		for (int r = 0; r < 2; r++) begin
			for (int i = 0; i < 3; i++) begin
				q_s4[r][i] <= sat32(64'(p_s3[r][i]) - 64'(base_q[i]));
			end
		end
		short_s4 <= short_s3;
	end

	// s5: per-component products with the axis
	always_ff @(posedge clk) begin
		for (int r = 0; r < 2; r++) begin
			for (int i = 0; i < 3; i++) begin
				dp_s5[r][i] <= prod_t'(q_s4[r][i]) * prod_t'(axis_q[i]);
			end
		end
		short_s5 <= short_s4;
	end

	// s6: height = sat(floor(sum >> FRAC_BITS)), window check
	always_ff @(posedge clk) begin
		for (int r = 0; r < 2; r++) begin
			coord_t h;
			h = sat32(64'((dot_t'(dp_s5[r][0]) + dot_t'(dp_s5[r][1])
				+ dot_t'(dp_s5[r][2])) >>> FRAC_BITS));
			ok_s6[r] <= (h >= 0) && (h >= height_low_q) && (h <= height_high_q);
		end
		short_s6 <= short_s5;
	end

	// s7: root selection into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit       <= 1'b0;
			drop_near <= 1'b0;
		end else if (!vld_s6) begin
			hit       <= 1'b0;
			drop_near <= 1'b0;
		end else if (short_s6) begin
			hit       <= ok_s6[1];
			drop_near <= 1'b0;
		end else begin
			hit       <= ok_s6[0] | ok_s6[1];
			drop_near <= ~ok_s6[0] & ok_s6[1];
		end
	end

`ifndef SYNTHESIS
	// every accepted transaction produces its result strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |-> ##7 done)
		else $error("result strobe missing after accepted transaction");

	// drop_near only together with a far-root hit
	a_drop_has_hit: assert property (@(posedge clk) disable iff (!arst_n)
		drop_near |-> hit && done)
		else $error("drop_near without hit");

	// result fields stay quiet between strobes
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !hit && !drop_near)
		else $error("result fields active without strobe");

	// no strobe without an earlier accepted transaction
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		##7 done |-> $past(in_take, 7))
		else $error("result strobe without a transaction");
`endif

endmodule
